[rtl/skt_pkg.sv]
// Shared types and constants for the sorted key table.
package skt_pkg;

   localparam int CAPACITY     = 256;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 16;
   localparam int ADDR_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STAT_INSERTED  = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_LOOKUP    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_MATCH,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]   position;
      logic                    found;
      logic [PAYLOAD_BITS-1:0] stored_payload;
      status_type              status;
      logic [COUNT_BITS-1:0]   entry_total;
   } result_type;

endpackage

[rtl/skt_if.sv]
// Request and response channel interfaces of the sorted key table.
interface skt_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [skt_pkg::KEY_BITS-1:0]      key;
   logic [skt_pkg::PAYLOAD_BITS-1:0]  payload;

   modport source (output valid, kind, key, payload, input ready);
   modport sink   (input valid, kind, key, payload, output ready);
endinterface

interface skt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [skt_pkg::COUNT_BITS-1:0]    position;
   logic                              found;
   logic [skt_pkg::PAYLOAD_BITS-1:0]  stored_payload;
   logic [1:0]                        status;
   logic [skt_pkg::COUNT_BITS-1:0]    entry_total;

   modport source (output valid, position, found, stored_payload, status, entry_total,
                   input ready);
   modport sink   (input valid, position, found, stored_payload, status, entry_total,
                   output ready);
endinterface

[rtl/sorted_key_table_insert_search_core.sv]
// Sorted key table: binary-search lookup and shifting insert over one entry RAM.
// A request runs a binary search for the lower bound, then reads that entry for a match; an
// insert of a new key also shifts the entries above its position up before writing it.
// A new request is taken only when the sequencer is idle, after the last result is handed on.
// Reset clears the entry count and control; RAM contents are left as they are.
module sorted_key_table_insert_search_core (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_if,
   skt_rsp_if.source rsp_if
);

   logic                                 res_valid;
   logic                                 res_ready;
   skt_pkg::result_type                  res_data;
   logic                                 mem_wr_en;
   logic [skt_pkg::ADDR_BITS-1:0]        mem_wr_addr;
   logic [skt_pkg::ENTRY_BITS-1:0]       mem_wr_data;
   logic                                 mem_rd_en;
   logic [skt_pkg::ADDR_BITS-1:0]        mem_rd_addr;
   logic [skt_pkg::ENTRY_BITS-1:0]       mem_rd_data;

   logic                                 rsp_valid_ff, rsp_valid_in;
   skt_pkg::result_type                  rsp_ff, rsp_in;

   skt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   skt_ram #(
      .WIDTH (skt_pkg::ENTRY_BITS),
      .DEPTH (skt_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // take a new result whenever the output register is empty or draining
   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.position       = rsp_ff.position;
   assign rsp_if.found          = rsp_ff.found;
   assign rsp_if.stored_payload = rsp_ff.stored_payload;
   assign rsp_if.status         = rsp_ff.status;
   assign rsp_if.entry_total    = rsp_ff.entry_total;

endmodule

[rtl/skt_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/skt_ctrl.sv]
// Search, shift and insert sequencer around the entry RAM.
module skt_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   skt_req_if.sink                           req_if,
   output logic                              res_valid,
   input  logic                              res_ready,
   output skt_pkg::result_type               res_data,
   output logic                              mem_wr_en,
   output logic [skt_pkg::ADDR_BITS-1:0]     mem_wr_addr,
   output logic [skt_pkg::ENTRY_BITS-1:0]    mem_wr_data,
   output logic                              mem_rd_en,
   output logic [skt_pkg::ADDR_BITS-1:0]     mem_rd_addr,
   input  logic [skt_pkg::ENTRY_BITS-1:0]    mem_rd_data
);

   skt_pkg::state_type                   state_ff, state_in;
   logic [skt_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   skt_pkg::kind_type                    kind_ff, kind_in;
   logic [skt_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic [skt_pkg::PAYLOAD_BITS-1:0]     payload_ff, payload_in;
   logic [skt_pkg::COUNT_BITS-1:0]       lo_ff, lo_in;
   logic [skt_pkg::COUNT_BITS-1:0]       hi_ff, hi_in;
   logic [skt_pkg::COUNT_BITS-1:0]       mid_ff, mid_in;
   logic [skt_pkg::ADDR_BITS-1:0]        sh_ff, sh_in;
   logic                                 in_range_ff, in_range_in;
   logic                                 found_ff, found_in;
   logic [skt_pkg::PAYLOAD_BITS-1:0]     stored_ff, stored_in;
   skt_pkg::status_type                  status_ff, status_in;

   skt_pkg::entry_type                   rd_entry;
   skt_pkg::entry_type                   new_entry;
   logic [skt_pkg::COUNT_BITS-1:0]       mid;
   logic [skt_pkg::COUNT_BITS-1:0]       last_idx;
   logic                                 hit;

   assign rd_entry  = skt_pkg::entry_type'(mem_rd_data);
   assign new_entry = '{key: key_ff, payload: payload_ff};
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_idx  = count_ff - skt_pkg::COUNT_BITS'(1);
   assign hit       = in_range_ff && (rd_entry.key == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skt_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      payload_ff  <= payload_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      sh_ff       <= sh_in;
      in_range_ff <= in_range_in;
      found_ff    <= found_in;
      stored_ff   <= stored_in;
      status_ff   <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      payload_in  = payload_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      sh_in       = sh_ff;
      in_range_in = in_range_ff;
      found_in    = found_ff;
      stored_in   = stored_ff;
      status_in   = status_ff;

      req_if.ready = 1'b0;
      res_valid    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = sh_ff + skt_pkg::ADDR_BITS'(1);
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = mid[skt_pkg::ADDR_BITS-1:0];

      case (state_ff)
         skt_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               kind_in    = skt_pkg::kind_type'(req_if.kind);
               key_in     = req_if.key;
               payload_in = req_if.payload;
               lo_in      = '0;
               hi_in      = count_ff;
               state_in   = skt_pkg::ST_SEARCH;
            end
         end
         skt_pkg::ST_SEARCH: begin
            mem_rd_en = 1'b1;
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = skt_pkg::ST_COMPARE;
            end else begin
               // read the lower-bound entry to test for an exact match
               mem_rd_addr = lo_ff[skt_pkg::ADDR_BITS-1:0];
               in_range_in = lo_ff < count_ff;
               state_in    = skt_pkg::ST_MATCH;
            end
         end
         skt_pkg::ST_COMPARE: begin
            if (rd_entry.key < key_ff) begin
               lo_in = mid_ff + skt_pkg::COUNT_BITS'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = skt_pkg::ST_SEARCH;
         end
         skt_pkg::ST_MATCH: begin
            found_in  = hit;
            stored_in = hit ? rd_entry.payload : '0;
            if (kind_ff == skt_pkg::KIND_LOOKUP) begin
               status_in = skt_pkg::STAT_LOOKUP;
               state_in  = skt_pkg::ST_DONE;
            end else if (hit) begin
               status_in = skt_pkg::STAT_DUPLICATE;
               state_in  = skt_pkg::ST_DONE;
            end else if (count_ff == skt_pkg::COUNT_BITS'(skt_pkg::CAPACITY)) begin
               status_in = skt_pkg::STAT_FULL;
               state_in  = skt_pkg::ST_DONE;
            end else if (count_ff > lo_ff) begin
               // start moving the tail up from the top entry down
               mem_rd_en   = 1'b1;
               mem_rd_addr = last_idx[skt_pkg::ADDR_BITS-1:0];
               sh_in       = last_idx[skt_pkg::ADDR_BITS-1:0];
               state_in    = skt_pkg::ST_SHIFT;
            end else begin
               state_in = skt_pkg::ST_PLACE;
            end
         end
         skt_pkg::ST_SHIFT: begin
            mem_wr_en = 1'b1;
            if ({1'b0, sh_ff} > lo_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = sh_ff - skt_pkg::ADDR_BITS'(1);
               sh_in       = sh_ff - skt_pkg::ADDR_BITS'(1);
            end else begin
               state_in = skt_pkg::ST_PLACE;
            end
         end
         skt_pkg::ST_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = lo_ff[skt_pkg::ADDR_BITS-1:0];
            mem_wr_data = new_entry;
            count_in    = count_ff + skt_pkg::COUNT_BITS'(1);
            status_in   = skt_pkg::STAT_INSERTED;
            state_in    = skt_pkg::ST_DONE;
         end
         skt_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = skt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skt_pkg::ST_IDLE;
         end
      endcase
   end

   assign res_data = '{position:       lo_ff,
                       found:          found_ff,
                       stored_payload: stored_ff,
                       status:         status_ff,
                       entry_total:    count_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skt_pkg::COUNT_BITS'(skt_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::ST_SEARCH) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search bounds out of order");

   a_place_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::ST_PLACE) |=>
         (count_ff == $past(count_ff) + skt_pkg::COUNT_BITS'(1)))
      else $error("insert did not grow the table");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != skt_pkg::ST_PLACE) |=> $stable(count_ff))
      else $error("entry count moved outside insert");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::ST_SHIFT) |->
         ({1'b0, sh_ff} >= lo_ff && {1'b0, sh_ff} < count_ff))
      else $error("shift index outside tail");

endmodule

[dv/tb_sorted_key_table_insert_search_core.sv]
// Self-checking testbench for the sorted key table: directed rows, then random fill and load.
`timescale 1ns / 100ps

module tb_sorted_key_table_insert_search_core;

   typedef struct {
      skt_pkg::kind_type                kind;
      logic [skt_pkg::KEY_BITS-1:0]     key;
      logic [skt_pkg::PAYLOAD_BITS-1:0] payload;
      bit                               typed;
      skt_pkg::result_type              want;
   } stim_row_type;

   logic clock;
   logic reset;

   skt_req_if req_ch ();
   skt_rsp_if rsp_ch ();

   sorted_key_table_insert_search_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Mirror of the table contents, kept in ascending key order.
   logic [skt_pkg::KEY_BITS-1:0]     mirror_key     [skt_pkg::CAPACITY];
   logic [skt_pkg::PAYLOAD_BITS-1:0] mirror_payload [skt_pkg::CAPACITY];
   int                               mirror_count;

   skt_pkg::result_type replies_due[$];
   skt_pkg::result_type oldest_reply;
   stim_row_type        directed_rows[$];

   int mismatch_count;
   int requests_sent;
   int inserted_count;
   int duplicate_count;
   int dropped_count;
   int lookup_count;
   int lookup_hits;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("timeout with %0d replies outstanding", replies_due.size());
      $display("tb_sorted_key_table_insert_search_core: errors");
      $finish;
   end

   // Binary search for the lower bound, then for an insert of a new key with room left, shift and insert.
   function automatic skt_pkg::result_type apply_to_table(
         skt_pkg::kind_type kind, logic [skt_pkg::KEY_BITS-1:0] key,
         logic [skt_pkg::PAYLOAD_BITS-1:0] payload);
      skt_pkg::result_type r;
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = mirror_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (mirror_key[skt_pkg::ADDR_BITS'(mid)] < key) lo = mid + 1;
         else hi = mid;
      end
      r.position       = skt_pkg::COUNT_BITS'(lo);
      r.found          = 1'b0;
      r.stored_payload = '0;
      if (lo < mirror_count && mirror_key[skt_pkg::ADDR_BITS'(lo)] == key) begin
         r.found          = 1'b1;
         r.stored_payload = mirror_payload[skt_pkg::ADDR_BITS'(lo)];
      end
      if (kind == skt_pkg::KIND_LOOKUP) begin
         r.status = skt_pkg::STAT_LOOKUP;
         lookup_count++;
         if (r.found) lookup_hits++;
      end else if (r.found) begin
         r.status = skt_pkg::STAT_DUPLICATE;
         duplicate_count++;
      end else if (mirror_count >= skt_pkg::CAPACITY) begin
         r.status = skt_pkg::STAT_FULL;
         dropped_count++;
      end else begin
         for (int i = mirror_count; i > lo; i--) begin
            mirror_key[skt_pkg::ADDR_BITS'(i)]     = mirror_key[skt_pkg::ADDR_BITS'(i-1)];
            mirror_payload[skt_pkg::ADDR_BITS'(i)] = mirror_payload[skt_pkg::ADDR_BITS'(i-1)];
         end
         mirror_key[skt_pkg::ADDR_BITS'(lo)]     = key;
         mirror_payload[skt_pkg::ADDR_BITS'(lo)] = payload;
         mirror_count++;
         r.status = skt_pkg::STAT_INSERTED;
         inserted_count++;
      end
      r.entry_total = skt_pkg::COUNT_BITS'(mirror_count);
      return r;
   endfunction

   function automatic logic [skt_pkg::KEY_BITS-1:0] held_key();
      if (mirror_count == 0) return $urandom;
      return mirror_key[skt_pkg::ADDR_BITS'($urandom_range(0, mirror_count - 1))];
   endfunction

   function automatic void check_field(string label, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic add_row(skt_pkg::kind_type kind, logic [skt_pkg::KEY_BITS-1:0] key,
                          logic [skt_pkg::PAYLOAD_BITS-1:0] payload, int typed, int pos,
                          int found, int stored, skt_pkg::status_type status, int total);
      stim_row_type row;
      row.kind                = kind;
      row.key                 = key;
      row.payload             = payload;
      row.typed               = (typed != 0);
      row.want.position       = skt_pkg::COUNT_BITS'(pos);
      row.want.found          = (found != 0);
      row.want.stored_payload = skt_pkg::PAYLOAD_BITS'(stored);
      row.want.status         = status;
      row.want.entry_total    = skt_pkg::COUNT_BITS'(total);
      directed_rows.push_back(row);
   endtask

   // Offer one request beat; predict once it is taken.
   task automatic drive_op(skt_pkg::kind_type kind, logic [skt_pkg::KEY_BITS-1:0] key,
                           logic [skt_pkg::PAYLOAD_BITS-1:0] payload, bit typed,
                           skt_pkg::result_type want);
      int gap;
      skt_pkg::result_type predicted;
      gap = ((requests_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.key     <= key;
      req_ch.payload <= payload;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_to_table(kind, key, payload);
      replies_due.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   // Response side: random ready gaps, one long hold-off to back the block up.
   initial begin
      int gap;
      int beats;
      beats = 0;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (beats == 120) begin
            rsp_ch.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         gap = ((beats / 50) % 3 == 2) ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         beats++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected reply beat, expected none, actual pos %0d status %0d",
                     $time, rsp_ch.position, rsp_ch.status);
            mismatch_count++;
         end else begin
            oldest_reply = replies_due.pop_front();
            check_field("position", 64'(oldest_reply.position), 64'(rsp_ch.position));
            check_field("found", 64'(oldest_reply.found), 64'(rsp_ch.found));
            check_field("stored_payload", 64'(oldest_reply.stored_payload),
                        64'(rsp_ch.stored_payload));
            check_field("status", 64'(oldest_reply.status), 64'(rsp_ch.status));
            check_field("entry_total", 64'(oldest_reply.entry_total),
                        64'(rsp_ch.entry_total));
         end
      end
   end

   initial begin
      skt_pkg::result_type              none;
      skt_pkg::kind_type                kind;
      logic [skt_pkg::KEY_BITS-1:0]     key;
      logic [skt_pkg::PAYLOAD_BITS-1:0] payload;
      int unsigned                      roll;

      none           = '0;
      mismatch_count = 0;
      requests_sent  = 0;
      mirror_count   = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= skt_pkg::KIND_INSERT;
      req_ch.key     <= '0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // lookup on empty table, extremes, duplicates, misses at both ends
      add_row(skt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'h0000, 1, 0, 0, 16'h0000,
              skt_pkg::STAT_LOOKUP, 0);
      add_row(skt_pkg::KIND_INSERT, 32'h0000_0040, 16'h0040, 1, 0, 0, 16'h0000,
              skt_pkg::STAT_INSERTED, 1);
      add_row(skt_pkg::KIND_LOOKUP, 32'h0000_0041, 16'hFFFF, 1, 1, 0, 16'h0000,
              skt_pkg::STAT_LOOKUP, 1);
      add_row(skt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 0, 16'h0000,
              skt_pkg::STAT_INSERTED, 2);
      add_row(skt_pkg::KIND_INSERT, 32'h0000_0000, 16'h0000, 1, 0, 0, 16'h0000,
              skt_pkg::STAT_INSERTED, 3);
      add_row(skt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 2, 1, 16'hFFFF,
              skt_pkg::STAT_LOOKUP, 3);
      add_row(skt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'h1234, 1, 0, 1, 16'h0000,
              skt_pkg::STAT_LOOKUP, 3);
      add_row(skt_pkg::KIND_INSERT, 32'h0000_0000, 16'hABCD, 1, 0, 1, 16'h0000,
              skt_pkg::STAT_DUPLICATE, 3);
      add_row(skt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'h0000, 1, 2, 1, 16'hFFFF,
              skt_pkg::STAT_DUPLICATE, 3);
      add_row(skt_pkg::KIND_INSERT, 32'h8000_0000, 16'h5555, 1, 2, 0, 16'h0000,
              skt_pkg::STAT_INSERTED, 4);
      add_row(skt_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1, 2, 0, 16'h0000,
              skt_pkg::STAT_LOOKUP, 4);
      add_row(skt_pkg::KIND_LOOKUP, 32'h8000_0001, 16'h0000, 1, 3, 0, 16'h0000,
              skt_pkg::STAT_LOOKUP, 4);
      add_row(skt_pkg::KIND_LOOKUP, 32'h0000_0040, 16'h0000, 1, 1, 1, 16'h0040,
              skt_pkg::STAT_LOOKUP, 4);
      add_row(skt_pkg::KIND_INSERT, 32'h0000_0001, 16'hAAAA, 1, 1, 0, 16'h0000,
              skt_pkg::STAT_INSERTED, 5);
      add_row(skt_pkg::KIND_INSERT, 32'hFFFF_FFFE, 16'h0001, 1, 4, 0, 16'h0000,
              skt_pkg::STAT_INSERTED, 6);
      add_row(skt_pkg::KIND_LOOKUP, 32'hFFFF_FFFE, 16'h0000, 1, 4, 1, 16'h0001,
              skt_pkg::STAT_LOOKUP, 6);
      add_row(skt_pkg::KIND_INSERT, 32'h1234_5678, 16'h8001, 0, 0, 0, 0,
              skt_pkg::STAT_INSERTED, 0);
      add_row(skt_pkg::KIND_LOOKUP, 32'h1234_5678, 16'h7FFE, 0, 0, 0, 0,
              skt_pkg::STAT_LOOKUP, 0);
      add_row(skt_pkg::KIND_INSERT, 32'h0000_0002, 16'h0002, 0, 0, 0, 0,
              skt_pkg::STAT_INSERTED, 0);
      add_row(skt_pkg::KIND_LOOKUP, 32'h0000_0003, 16'h0000, 0, 0, 0, 0,
              skt_pkg::STAT_LOOKUP, 0);
      add_row(skt_pkg::KIND_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 0, 0, 0, 0,
              skt_pkg::STAT_INSERTED, 0);
      add_row(skt_pkg::KIND_LOOKUP, 32'h0000_0001, 16'h0000, 0, 0, 0, 0,
              skt_pkg::STAT_LOOKUP, 0);
      foreach (directed_rows[i])
         drive_op(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].payload,
                  directed_rows[i].typed, directed_rows[i].want);

      // mixed traffic on a partly filled table: clustered keys, duplicates, near misses
      repeat (200) begin
         kind    = $urandom_range(0, 1) ? skt_pkg::KIND_LOOKUP : skt_pkg::KIND_INSERT;
         payload = skt_pkg::PAYLOAD_BITS'($urandom);
         roll    = $urandom_range(0, 3);
         case (roll)
            0: key = $urandom;
            1: key = held_key();
            2: key = $urandom_range(0, 63);
            default: key = held_key() + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
         endcase
         drive_op(kind, key, payload, 1'b0, none);
      end

      // fill to capacity, with lookups of held keys mixed in
      while (mirror_count < skt_pkg::CAPACITY) begin
         if ($urandom_range(0, 4) == 0)
            drive_op(skt_pkg::KIND_LOOKUP, held_key(), skt_pkg::PAYLOAD_BITS'($urandom),
                     1'b0, none);
         else
            drive_op(skt_pkg::KIND_INSERT, $urandom, skt_pkg::PAYLOAD_BITS'($urandom),
                     1'b0, none);
      end

      // full table: dropped inserts, duplicates, lookups, extreme keys
      repeat (260) begin
         payload = skt_pkg::PAYLOAD_BITS'($urandom);
         roll    = $urandom_range(0, 19);
         if (roll == 0) key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         else if (roll < 10) key = $urandom;
         else key = held_key();
         kind = ($urandom_range(0, 9) < 6) ? skt_pkg::KIND_INSERT : skt_pkg::KIND_LOOKUP;
         drive_op(kind, key, payload, 1'b0, none);
      end
      req_ch.valid <= 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("ran %0d requests: %0d inserted, %0d duplicate, %0d dropped on full table",
               requests_sent, inserted_count, duplicate_count, dropped_count);
      $display("%0d lookups (%0d hits), final occupancy %0d of %0d",
               lookup_count, lookup_hits, mirror_count, skt_pkg::CAPACITY);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("tb_sorted_key_table_insert_search_core: clean");
      end else begin
         $display("tb_sorted_key_table_insert_search_core: errors");
      end
      $finish;
   end

endmodule
